FILE: rtl/cascaded_biquad_lowpass_defines.svh
// Assertion macros shared by the biquad cascade RTL.
`ifndef CASCADED_BIQUAD_LOWPASS_DEFINES_SVH
`define CASCADED_BIQUAD_LOWPASS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cbl_pkg.sv
// Package: types, widths and register codes of the biquad cascade.
package cbl_pkg;

  localparam int SECTIONS_DEF = 2;
  localparam int MAX_SECTIONS = 2;
  localparam int SEC_IW       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int COEF_N       = 2 * MAX_SECTIONS;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 32;
  localparam int CREG_W   = 64;
  localparam int HIST_W   = 40;
  localparam int ACC_W    = 45;
  localparam int MAG_W    = 44;
  localparam int MUL_AW   = 24;
  localparam int MUL_BW   = 32;
  localparam int PROD_W   = MUL_AW + MUL_BW;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 64;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h1000_0000;

  localparam logic [CFG_AW-1:0] REG_INPUT_GAIN = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SEC0_POLES = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SEC0_ZEROS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SEC1_POLES = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SEC1_ZEROS = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN_MUL,
    ST_GAIN_RND,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_COMB,
    ST_SAT_W,
    ST_SAT_Y,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic              gain_mul;
    logic              gain_rnd;
    logic              mul_lo;
    logic              mul_hi;
    logic              comb;
    logic              sat_w;
    logic              sat_y;
    logic              fin;
    logic [1:0]        k;
    logic [SEC_IW-1:0] sec;
  } cbl_ctl_t;

endpackage

FILE: rtl/cbl_mul.sv
// Shared 24x32 unsigned multiplier with registered product.
module cbl_mul import cbl_pkg::*; (
  input  logic              clk,
  input  logic [MUL_AW-1:0] a,
  input  logic [MUL_BW-1:0] b,
  output logic [PROD_W-1:0] p
);

  logic [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

FILE: rtl/cbl_ctrl.sv
// Sequencer: steps the shared multiplier through gain and section products.
`include "cascaded_biquad_lowpass_defines.svh"

module cbl_ctrl import cbl_pkg::*; #(
  parameter int SECTIONS = SECTIONS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  output logic     in_tready,
  output cbl_ctl_t ctl
);

  localparam int NSEC = (SECTIONS < 1) ? 1 : ((SECTIONS > MAX_SECTIONS) ? MAX_SECTIONS : SECTIONS);
  localparam logic [SEC_IW-1:0] LAST_SEC = SEC_IW'(NSEC - 1);

  state_t            state_r, state_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [SEC_IW-1:0] sec_r, sec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 2'd0;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      sec_r   <= sec_nxt;
    end
  end

  // next state and product/section counters
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_GAIN_MUL;
      ST_GAIN_MUL: state_nxt = ST_GAIN_RND;
      ST_GAIN_RND: begin
        state_nxt = ST_MUL_LO;
        k_nxt     = 2'd0;
        sec_nxt   = '0;
      end
      ST_MUL_LO:   state_nxt = ST_MUL_HI;
      ST_MUL_HI:   state_nxt = ST_COMB;
      ST_COMB: begin
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd1)      state_nxt = ST_SAT_W;
        else if (k_r == 2'd3) state_nxt = ST_SAT_Y;
        else                  state_nxt = ST_MUL_LO;
      end
      ST_SAT_W:    state_nxt = ST_MUL_LO;
      ST_SAT_Y: begin
        if (sec_r == LAST_SEC) begin
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_MUL_LO;
          sec_nxt   = sec_r + SEC_IW'(1);
        end
      end
      ST_FINAL:    if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // decoded strobes
  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    ctl.gain_mul = (state_r == ST_GAIN_MUL);
    ctl.gain_rnd = (state_r == ST_GAIN_RND);
    ctl.mul_lo   = (state_r == ST_MUL_LO);
    ctl.mul_hi   = (state_r == ST_MUL_HI);
    ctl.comb     = (state_r == ST_COMB);
    ctl.sat_w    = (state_r == ST_SAT_W);
    ctl.sat_y    = (state_r == ST_SAT_Y);
    ctl.fin      = (state_r == ST_FINAL);
    ctl.k        = k_r;
    ctl.sec      = sec_r;
  end

  `CBL_ASSERT_IMP(a_satw_after_poles, clk, rst_n, state_r == ST_SAT_W, k_r == 2'd2, "w saturation not after both pole products")
  `CBL_ASSERT_IMP(a_saty_after_zeros, clk, rst_n, state_r == ST_SAT_Y, k_r == 2'd0, "y saturation not after both zero products")
  `CBL_ASSERT_IMP(a_idle_counter_clear, clk, rst_n, in_tready, k_r == 2'd0, "product counter not wrapped when ready")

endmodule

FILE: rtl/cascaded_biquad_lowpass.sv
// Top level: fixed-point direct-form-II biquad cascade with shared multiplier.
//
// One sample word in, one filtered word out. A new sample is taken only once
// the last one has been through every section and the output step. The number
// of sections in use is SECTIONS, limited to 1..2. The work is paced by the
// single 24x32 multiplier, which is used twice for each of the four
// history-by-coefficient products of a section (low and high half of the
// 40-bit history), plus a combine step per product, two saturation steps per
// section, the gain multiply and round, and the output step. in_tready is
// high only between samples; the result sits in an output register, so the
// next sample is accepted while a result waits. out_tuser[0] flags that the
// output or any section value saturated. The user must write registers through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce this.
`include "cascaded_biquad_lowpass_defines.svh"

module cascaded_biquad_lowpass import cbl_pkg::*; #(
  parameter int SECTIONS = SECTIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [23:0] sample_in
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [SAMPLE_W-1:0] out_tdata,  // [23:0] sample_out
  output logic [0:0]          out_tuser,  // [0] clipped
  input  logic                cfg_we,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int NSEC   = (SECTIONS < 1) ? 1 : ((SECTIONS > MAX_SECTIONS) ? MAX_SECTIONS : SECTIONS);
  localparam int HIST_N = 2 * NSEC;
  localparam int HIDX_W = $clog2(HIST_N);

  cbl_ctl_t ctl;
  logic     in_fire;
  logic     out_free;

  logic [GAIN_W-1:0]          gain_r;
  logic [CREG_W-1:0]          coef_r [COEF_N];
  logic [HIST_W-1:0]          hist_r [HIST_N];
  logic [SAMPLE_W-1:0]        x_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [HIST_W-1:0]          w_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       sub_r;
  logic                       pend_r;
  logic [PROD_W-1:0]          plo_r;
  logic                       clip_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;
  logic                       out_clip_r;

  logic [SEC_IW:0]            hidx_full;
  logic [SEC_IW:0]            cidx;
  logic [HIDX_W-1:0]          h1_idx, h2_idx;
  logic [HIST_W-1:0]          h_sel, h_mag;
  logic [CREG_W-1:0]          c_word;
  logic [31:0]                c_sel, c_mag;
  logic [SAMPLE_W-1:0]        x_mag;
  logic [MUL_AW-1:0]          mul_a;
  logic [MUL_BW-1:0]          mul_b;
  logic [PROD_W-1:0]          prod;

  logic [52:0]                t_sum;
  logic [MAG_W-1:0]           r_mag;
  logic signed [ACC_W-1:0]    mag_ext;
  logic signed [ACC_W-1:0]    acc_sum;
  logic                       hist_ovf;
  logic [HIST_W-1:0]          hist_sat;

  logic [PROD_W:0]            g_sum;
  logic [37:0]                g_mag;
  logic signed [ACC_W-1:0]    g_ext, g_val;

  logic [HIST_W-1:0]          a40, f_mag;
  logic [HIST_W:0]            f_sum;
  logic [31:0]                f_r;
  logic                       f_clip;
  logic [SAMPLE_W-1:0]        f_val;

  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  cbl_ctrl #(.SECTIONS(SECTIONS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_free  (out_free),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
      for (int i = 0; i < COEF_N; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_INPUT_GAIN: gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_SEC0_POLES: coef_r[0] <= cfg_wdata;
        REG_SEC0_ZEROS: coef_r[1] <= cfg_wdata;
        REG_SEC1_POLES: coef_r[2] <= cfg_wdata;
        REG_SEC1_ZEROS: coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand selection: k[0] picks h1/h2 and beta1/beta2, k[1] poles/zeros
  assign hidx_full = {ctl.sec, ctl.k[0]};
  assign cidx      = {ctl.sec, ctl.k[1]};
  assign h1_idx    = HIDX_W'({ctl.sec, 1'b0});
  assign h2_idx    = HIDX_W'({ctl.sec, 1'b1});
  assign h_sel     = hist_r[hidx_full[HIDX_W-1:0]];
  assign c_word    = coef_r[cidx];
  assign c_sel     = ctl.k[0] ? c_word[63:32] : c_word[31:0];
  assign h_mag     = h_sel[HIST_W-1] ? (~h_sel + 40'd1) : h_sel;
  assign c_mag     = c_sel[31] ? (~c_sel + 32'd1) : c_sel;
  assign x_mag     = x_r[SAMPLE_W-1] ? (~x_r + 24'd1) : x_r;

  always_comb begin
    if (ctl.gain_mul) begin
      mul_a = x_mag;
      mul_b = gain_r;
    end else if (ctl.mul_hi) begin
      mul_a = {4'd0, h_mag[39:20]};
      mul_b = c_mag;
    end else begin
      mul_a = {4'd0, h_mag[19:0]};
      mul_b = c_mag;
    end
  end

  cbl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // lo + hi<<20, rounded at bit 28; hi low byte folded into the lo sum
  assign t_sum = {1'b0, plo_r[51:0]} + {25'd0, prod[7:0], 20'd0} + 53'h800_0000;
  assign r_mag = prod[51:8] + {19'd0, t_sum[52:28]};

  assign mag_ext = $signed({1'b0, mag_r});
  always_comb begin
    if (!pend_r)    acc_sum = acc_r;
    else if (sub_r) acc_sum = acc_r - mag_ext;
    else            acc_sum = acc_r + mag_ext;
  end

  assign hist_ovf = ~((&acc_sum[ACC_W-1:HIST_W-1]) | ~(|acc_sum[ACC_W-1:HIST_W-1]));
  always_comb begin
    if (!hist_ovf)                hist_sat = acc_sum[HIST_W-1:0];
    else if (acc_sum[ACC_W-1])    hist_sat = 40'h80_0000_0000;
    else                          hist_sat = 40'h7F_FFFF_FFFF;
  end

  // gain product rounded to Q8.32, ties away from zero
  assign g_sum = {1'b0, prod} + 57'h4_0000;
  assign g_mag = g_sum[56:19];
  assign g_ext = $signed({7'd0, g_mag});
  assign g_val = x_r[SAMPLE_W-1] ? -g_ext : g_ext;

  // Q8.32 to Q1.23 with saturation
  assign a40    = acc_r[HIST_W-1:0];
  assign f_mag  = a40[HIST_W-1] ? (~a40 + 40'd1) : a40;
  assign f_sum  = {1'b0, f_mag} + 41'd256;
  assign f_r    = f_sum[40:9];
  assign f_clip = a40[HIST_W-1] ? (f_r > 32'd8388608) : (f_r > 32'd8388607);
  always_comb begin
    if (f_clip)                f_val = a40[HIST_W-1] ? 24'h80_0000 : 24'h7F_FFFF;
    else if (a40[HIST_W-1])    f_val = 24'd0 - f_r[23:0];
    else                       f_val = f_r[23:0];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) x_r <= in_tdata;
    if (ctl.mul_hi) plo_r <= prod;
    if (ctl.comb) begin
      mag_r <= r_mag;
      sub_r <= h_sel[HIST_W-1] ^ c_sel[31] ^ ~ctl.k[1];
    end
    if (ctl.gain_rnd)                acc_r <= g_val;
    else if (ctl.sat_w || ctl.sat_y) acc_r <= {{(ACC_W-HIST_W){hist_sat[HIST_W-1]}}, hist_sat};
    else if (pend_r)                 acc_r <= acc_sum;
    if (ctl.sat_w) w_r <= hist_sat;
    if (ctl.gain_rnd)                               clip_r <= 1'b0;
    else if ((ctl.sat_w || ctl.sat_y) && hist_ovf)  clip_r <= 1'b1;
    if (ctl.fin && out_free) begin
      out_data_r <= f_val;
      out_clip_r <= clip_r | f_clip;
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HIST_N; i++) hist_r[i] <= '0;
    end else begin
      pend_r <= ctl.comb;
      if (ctl.fin && out_free) out_valid_r <= 1'b1;
      else if (out_tready)     out_valid_r <= 1'b0;
      if (ctl.sat_y) begin
        hist_r[h2_idx] <= hist_r[h1_idx];
        hist_r[h1_idx] <= w_r;
      end
    end
  end

  `CBL_ASSERT_IMP(a_pend_from_comb, clk, rst_n, pend_r, $past(ctl.comb), "pending accumulate without a combine step")
  `CBL_ASSERT_IMP(a_final_no_pend, clk, rst_n, ctl.fin, !pend_r, "output rounding while a product is still pending")
  `CBL_ASSERT_NXT(a_gain_no_pend, clk, rst_n, ctl.gain_mul, ctl.gain_rnd && !pend_r, "gain load overlaps a pending product")

endmodule
